/* design/gdc_pkg.sv */
// ----------------------------------------------------------------------------
// gdc_pkg: shared types and constants of the gamma dither corrector
// Register indexes, table layout, arithmetic constants and the tenth-root ROM.
// ----------------------------------------------------------------------------
package gdc_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
    localparam int INT_W         = 8;
    localparam int FRAC_W        = 3;
    localparam int ENTRY_W       = INT_W + FRAC_W;

    localparam logic [1:0] REG_GAMMA      = 2'd0;
    localparam logic [1:0] REG_OVERSAMPLE = 2'd1;
    localparam logic [1:0] REG_BRIGHTNESS = 2'd2;
    localparam logic [1:0] REG_GRB        = 2'd3;

    localparam logic [15:0] Y_START     = 16'd65280;
    localparam logic [31:0] ROUND_HALF  = 32'd32768;
    localparam logic [15:0] FULL_SCALE  = 16'd255;
    localparam logic [7:0]  DIV10_MUL   = 8'd205;
    localparam int          DIV10_SHIFT = 11;
    localparam logic [6:0]  TEN         = 7'd10;

    typedef struct packed {
        logic                 en;
        logic [ADDR_W-1:0]    addr;
        logic [ENTRY_W-1:0]   data;
    } tbl_wr_t;

    localparam logic [15:0] ROOT_ROM [TABLE_ENTRIES] = '{
        16'd0,16'd37654,16'd40357,16'd42027,16'd43253,16'd44229,16'd45043,16'd45743,
        16'd46358,16'd46907,16'd47404,16'd47858,16'd48276,16'd48664,16'd49026,16'd49366,
        16'd49685,16'd49987,16'd50274,16'd50546,16'd50806,16'd51055,16'd51293,16'd51521,
        16'd51741,16'd51953,16'd52157,16'd52354,16'd52545,16'd52730,16'd52909,16'd53082,
        16'd53251,16'd53415,16'd53575,16'd53731,16'd53882,16'd54030,16'd54174,16'd54315,
        16'd54453,16'd54588,16'd54719,16'd54848,16'd54974,16'd55098,16'd55219,16'd55338,
        16'd55455,16'd55569,16'd55682,16'd55792,16'd55901,16'd56007,16'd56112,16'd56215,
        16'd56316,16'd56416,16'd56514,16'd56611,16'd56706,16'd56800,16'd56892,16'd56984,
        16'd57073,16'd57162,16'd57249,16'd57335,16'd57420,16'd57504,16'd57587,16'd57669,
        16'd57750,16'd57829,16'd57908,16'd57986,16'd58063,16'd58139,16'd58214,16'd58288,
        16'd58361,16'd58434,16'd58506,16'd58576,16'd58647,16'd58716,16'd58785,16'd58853,
        16'd58920,16'd58987,16'd59053,16'd59118,16'd59183,16'd59247,16'd59310,16'd59373,
        16'd59435,16'd59497,16'd59558,16'd59618,16'd59678,16'd59738,16'd59796,16'd59855,
        16'd59913,16'd59970,16'd60027,16'd60083,16'd60139,16'd60195,16'd60250,16'd60304,
        16'd60358,16'd60412,16'd60465,16'd60518,16'd60571,16'd60623,16'd60674,16'd60725,
        16'd60776,16'd60827,16'd60877,16'd60927,16'd60976,16'd61025,16'd61073,16'd61122,
        16'd61170,16'd61217,16'd61265,16'd61312,16'd61358,16'd61405,16'd61451,16'd61496,
        16'd61542,16'd61587,16'd61632,16'd61676,16'd61720,16'd61764,16'd61808,16'd61851,
        16'd61894,16'd61937,16'd61980,16'd62022,16'd62064,16'd62106,16'd62148,16'd62189,
        16'd62230,16'd62271,16'd62311,16'd62352,16'd62392,16'd62432,16'd62471,16'd62511,
        16'd62550,16'd62589,16'd62628,16'd62666,16'd62705,16'd62743,16'd62781,16'd62818,
        16'd62856,16'd62893,16'd62930,16'd62967,16'd63004,16'd63041,16'd63077,16'd63113,
        16'd63149,16'd63185,16'd63220,16'd63256,16'd63291,16'd63326,16'd63361,16'd63396,
        16'd63430,16'd63465,16'd63499,16'd63533,16'd63567,16'd63601,16'd63634,16'd63668,
        16'd63701,16'd63734,16'd63767,16'd63800,16'd63832,16'd63865,16'd63897,16'd63929,
        16'd63962,16'd63993,16'd64025,16'd64057,16'd64088,16'd64120,16'd64151,16'd64182,
        16'd64213,16'd64244,16'd64274,16'd64305,16'd64335,16'd64366,16'd64396,16'd64426,
        16'd64456,16'd64485,16'd64515,16'd64545,16'd64574,16'd64603,16'd64633,16'd64662,
        16'd64691,16'd64719,16'd64748,16'd64777,16'd64805,16'd64834,16'd64862,16'd64890,
        16'd64918,16'd64946,16'd64974,16'd65001,16'd65029,16'd65057,16'd65084,16'd65111,
        16'd65138,16'd65165,16'd65192,16'd65219,16'd65246,16'd65273,16'd65299,16'd65326,
        16'd65352,16'd65379,16'd65405,16'd65431,16'd65457,16'd65483,16'd65509,16'd65535
    };

    function automatic logic [FRAC_W-1:0] phase_mask_of(input logic [1:0] sh);
        logic [FRAC_W:0] one_hot;
        one_hot = (FRAC_W+1)'(1) << sh;
        return FRAC_W'(one_hot - (FRAC_W+1)'(1));
    endfunction

endpackage

/* design/gdc_table_ram.sv */
// ----------------------------------------------------------------------------
// gdc_table_ram: gamma curve table memory
// One write port and one read port with registered read data; each word holds
// the integer part above the fractional dither bits.
// ----------------------------------------------------------------------------
module gdc_table_ram
    import gdc_pkg::*;
(
    input  logic                 aclk,
    input  tbl_wr_t              wr,
    input  logic [ADDR_W-1:0]    rd_addr,
    output logic [ENTRY_W-1:0]   rd_data
);

    logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* design/gdc_curve_builder.sv */
// ----------------------------------------------------------------------------
// gdc_curve_builder: iterative gamma table generator
// Walks entries 1 to 255, running a shared rounding 16x16 multiplier over the
// whole powers, the tenth roots and the final scale, then writes each entry.
// ----------------------------------------------------------------------------
module gdc_curve_builder
    import gdc_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [7:0]    gamma_code,
    input  logic [1:0]    oversample_shift,
    output tbl_wr_t       wr,
    output logic          done
);

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_LOAD  = 2'd1;
    localparam logic [1:0] B_MUL   = 2'd2;
    localparam logic [1:0] B_WRITE = 2'd3;

    localparam logic [1:0] P_WHOLE = 2'd0;
    localparam logic [1:0] P_ROOT  = 2'd1;
    localparam logic [1:0] P_FINAL = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [3:0]        k_reg, k_next;
    logic [ADDR_W-1:0] x_reg, x_next;
    logic [15:0]       y_reg, y_next;
    logic [15:0]       root_reg, root_next;
    logic [3:0]        whole_reg, whole_next;
    logic [3:0]        roots_reg, roots_next;
    logic [1:0]        sh_reg, sh_next;
    logic              done_reg, done_next;

    logic [6:0]        tenths;
    logic [14:0]       quot;
    logic [3:0]        whole_calc;
    logic [3:0]        roots_calc;
    logic [15:0]       operand;
    logic [31:0]       product;
    logic [15:0]       mul_result;

    assign tenths     = gamma_code[7:1];
    assign quot       = 15'(tenths) * 15'(DIV10_MUL);
    assign whole_calc = quot[14:DIV10_SHIFT];
    assign roots_calc = 4'(tenths - 7'(whole_calc) * TEN);

    always_comb begin
        unique case (phase_reg)
            P_WHOLE: operand = {x_reg, x_reg};
            P_ROOT:  operand = root_reg;
            default: operand = 16'(FULL_SCALE << sh_reg);
        endcase
    end

    assign product    = 32'(y_reg) * 32'(operand) + ROUND_HALF;
    assign mul_result = product[31:16];

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        k_next     = k_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        root_next  = root_reg;
        whole_next = whole_reg;
        roots_next = roots_reg;
        sh_next    = sh_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            B_IDLE: begin
                if (start) begin
                    whole_next = whole_calc;
                    roots_next = roots_calc;
                    sh_next    = oversample_shift;
                    x_next     = ADDR_W'(1);
                    state_next = B_LOAD;
                end
            end
            B_LOAD: begin
                y_next     = Y_START;
                root_next  = ROOT_ROM[x_reg];
                k_next     = '0;
                phase_next = P_WHOLE;
                state_next = B_MUL;
            end
            B_MUL: begin
                priority case (phase_reg)
                    P_WHOLE: begin
                        if (k_reg < whole_reg) begin
                            y_next = mul_result;
                            k_next = k_reg + 4'd1;
                        end else begin
                            k_next     = '0;
                            phase_next = P_ROOT;
                        end
                    end
                    P_ROOT: begin
                        if (k_reg < roots_reg) begin
                            y_next = mul_result;
                            k_next = k_reg + 4'd1;
                        end else begin
                            phase_next = P_FINAL;
                        end
                    end
                    default: begin
                        y_next     = mul_result;
                        state_next = B_WRITE;
                    end
                endcase
            end
            default: begin
                if (x_reg == ADDR_W'(TABLE_ENTRIES - 1)) begin
                    done_next  = 1'b1;
                    state_next = B_IDLE;
                end else begin
                    x_next     = x_reg + ADDR_W'(1);
                    state_next = B_LOAD;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        phase_reg <= phase_next;
        k_reg     <= k_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        root_reg  <= root_next;
        whole_reg <= whole_next;
        roots_reg <= roots_next;
        sh_reg    <= sh_next;
    end

    assign wr.en   = (state_reg == B_WRITE);
    assign wr.addr = x_reg;
    assign wr.data = {INT_W'(y_reg >> sh_reg), y_reg[FRAC_W-1:0] & phase_mask_of(sh_reg)};
    assign done    = done_reg;

endmodule

/* design/gamma_dither_corrector_unit.sv */
// ----------------------------------------------------------------------------
// gamma_dither_corrector_unit: LED gamma correction with temporal dithering
// Scales pixel channels by brightness, maps them through a gamma table and
// rounds up by the dither phase; a rebuild item regenerates the table.
// ----------------------------------------------------------------------------
// Usage: items enter on the s_ stream (tuser 0 for a pixel, 1 for a table
// rebuild, tlast on the last pixel of a frame) and one result item leaves on
// the m_ stream for each, tuser 1 marking a finished rebuild with zero bytes.
// Registers are written on the cfg channel, which is always ready; the user
// must write them only while the block is idle, and the block does not enforce
// it. Items are handled one at a time: a pixel reads the single table memory
// port once per channel in ST_RD0 to ST_RD3 and is registered in ST_OUT before
// the next acceptance. A rebuild runs whole and then roots multiplications for
// each of entries 1 to 255, where whole and roots are the integer and tenth
// parts of gamma_code / 20; the builder runs one multiplication per cycle.
// Reset clears the registers to their defaults and marks the table as unbuilt,
// so table lookups read zero until the first rebuild. When the receiver stalls,
// the result waits in the output register; the next item may be accepted
// meanwhile but its result is held back until the register is free.
// ----------------------------------------------------------------------------
module gamma_dither_corrector_unit
    import gdc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
    input  logic        s_tuser,   // cmd
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // wire_byte0, wire_byte1, wire_byte2
    output logic        m_tuser,   // kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD0   = 3'd1;
    localparam logic [2:0] ST_RD1   = 3'd2;
    localparam logic [2:0] ST_RD2   = 3'd3;
    localparam logic [2:0] ST_RD3   = 3'd4;
    localparam logic [2:0] ST_BUILD = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [7:0]        gamma_reg;
    logic [1:0]        oversample_reg;
    logic [7:0]        brightness_reg;
    logic              grb_reg;
    logic              built_reg, built_next;
    logic [FRAC_W-1:0] dphase_reg, dphase_next;
    logic [FRAC_W-1:0] pmask_reg, pmask_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [23:0]       m_tdata_reg, m_tdata_next;
    logic              m_tuser_reg, m_tuser_next;

    logic              kind_reg;
    logic              last_reg;
    logic [7:0]        raw_reg [3];
    logic [ADDR_W-1:0] idx_reg [3];
    logic [7:0]        corr_reg [3];

    logic              accept;
    logic              out_free;
    logic [15:0]       scaled [3];
    logic [ADDR_W-1:0] rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic [ADDR_W-1:0] arr_idx;
    logic [INT_W-1:0]  look_int;
    logic [FRAC_W-1:0] look_frac;
    logic [7:0]        look_val;
    logic [7:0]        pix [3];
    tbl_wr_t           tbl_wr;
    logic              build_done;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            scaled[i] = 16'(s_tdata[8*i +: 8]) * 16'(brightness_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gamma_reg      <= '0;
            oversample_reg <= '0;
            brightness_reg <= 8'hFF;
            grb_reg        <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_GAMMA:      gamma_reg      <= cfg_data;
                REG_OVERSAMPLE: oversample_reg <= cfg_data[1:0];
                REG_BRIGHTNESS: brightness_reg <= cfg_data;
                REG_GRB:        grb_reg        <= cfg_data[0];
                default:        gamma_reg      <= gamma_reg;
            endcase
        end
    end

    gdc_curve_builder u_builder (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .start            (accept && s_tuser),
        .gamma_code       (gamma_reg),
        .oversample_shift (oversample_reg),
        .wr               (tbl_wr),
        .done             (build_done)
    );

    gdc_table_ram u_table (
        .aclk    (aclk),
        .wr      (tbl_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        unique case (state_reg)
            ST_RD1:  rd_addr = idx_reg[1];
            ST_RD2:  rd_addr = idx_reg[2];
            default: rd_addr = idx_reg[0];
        endcase
        unique case (state_reg)
            ST_RD2:  arr_idx = idx_reg[1];
            ST_RD3:  arr_idx = idx_reg[2];
            default: arr_idx = idx_reg[0];
        endcase
    end

    always_comb begin
        if (built_reg && arr_idx != '0) begin
            look_int  = rd_data[ENTRY_W-1:FRAC_W];
            look_frac = rd_data[FRAC_W-1:0];
        end else begin
            look_int  = '0;
            look_frac = '0;
        end
        if (look_frac > dphase_reg && look_int != 8'hFF) begin
            look_val = look_int + 8'd1;
        end else begin
            look_val = look_int;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= s_tuser;
            last_reg <= s_tlast;
            for (int i = 0; i < 3; i++) begin
                raw_reg[i] <= s_tdata[8*i +: 8];
                idx_reg[i] <= scaled[i][15:8];
            end
        end
        if (state_reg == ST_RD1) corr_reg[0] <= look_val;
        if (state_reg == ST_RD2) corr_reg[1] <= look_val;
        if (state_reg == ST_RD3) corr_reg[2] <= look_val;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pix[i] = (gamma_reg == 8'd0) ? raw_reg[i] : corr_reg[i];
        end
    end

    always_comb begin
        state_next    = state_reg;
        built_next    = built_reg;
        dphase_next   = dphase_reg;
        pmask_next    = pmask_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser) begin
                        pmask_next = phase_mask_of(oversample_reg);
                        state_next = ST_BUILD;
                    end else begin
                        state_next = ST_RD0;
                    end
                end
            end
            ST_RD0: state_next = ST_RD1;
            ST_RD1: state_next = ST_RD2;
            ST_RD2: state_next = ST_RD3;
            ST_RD3: state_next = ST_OUT;
            ST_BUILD: begin
                if (build_done) begin
                    built_next = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = kind_reg;
                    if (kind_reg) begin
                        m_tdata_next = '0;
                    end else begin
                        m_tdata_next = grb_reg ? {pix[2], pix[0], pix[1]}
                                               : {pix[2], pix[1], pix[0]};
                        if (last_reg) begin
                            dphase_next = (dphase_reg + FRAC_W'(1)) & pmask_reg;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            built_reg    <= 1'b0;
            dphase_reg   <= '0;
            pmask_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            built_reg    <= built_next;
            dphase_reg   <= dphase_next;
            pmask_reg    <= pmask_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* test/gamma_dither_corrector_unit_test.sv */
// ----------------------------------------------------------------------------
// gamma_dither_corrector_unit_test: self-checking regression of the LED gamma
// corrector
// Streams pixel and table rebuild items through the block under random
// back-pressure on both sides. An internal model builds its own gamma and
// fraction tables, tracks the dither phase and predicts every result. Each
// result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module gamma_dither_corrector_unit_test
    import gdc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_PIXEL    = 1'b0;
    localparam logic CMD_REBUILD  = 1'b1;
    localparam logic KIND_PIXEL   = 1'b0;
    localparam logic KIND_REBUILT = 1'b1;

    localparam int ITEM_TARGET   = 630;
    localparam int CLOSING_ITEMS = 60;
    localparam int QUIET_LIMIT   = 40000;
    localparam int HOLD_CYCLES   = 300;

    localparam logic [15:0] ROOT_Q16 [256] = '{
        0,37654,40357,42027,43253,44229,45043,45743,
        46358,46907,47404,47858,48276,48664,49026,49366,
        49685,49987,50274,50546,50806,51055,51293,51521,
        51741,51953,52157,52354,52545,52730,52909,53082,
        53251,53415,53575,53731,53882,54030,54174,54315,
        54453,54588,54719,54848,54974,55098,55219,55338,
        55455,55569,55682,55792,55901,56007,56112,56215,
        56316,56416,56514,56611,56706,56800,56892,56984,
        57073,57162,57249,57335,57420,57504,57587,57669,
        57750,57829,57908,57986,58063,58139,58214,58288,
        58361,58434,58506,58576,58647,58716,58785,58853,
        58920,58987,59053,59118,59183,59247,59310,59373,
        59435,59497,59558,59618,59678,59738,59796,59855,
        59913,59970,60027,60083,60139,60195,60250,60304,
        60358,60412,60465,60518,60571,60623,60674,60725,
        60776,60827,60877,60927,60976,61025,61073,61122,
        61170,61217,61265,61312,61358,61405,61451,61496,
        61542,61587,61632,61676,61720,61764,61808,61851,
        61894,61937,61980,62022,62064,62106,62148,62189,
        62230,62271,62311,62352,62392,62432,62471,62511,
        62550,62589,62628,62666,62705,62743,62781,62818,
        62856,62893,62930,62967,63004,63041,63077,63113,
        63149,63185,63220,63256,63291,63326,63361,63396,
        63430,63465,63499,63533,63567,63601,63634,63668,
        63701,63734,63767,63800,63832,63865,63897,63929,
        63962,63993,64025,64057,64088,64120,64151,64182,
        64213,64244,64274,64305,64335,64366,64396,64426,
        64456,64485,64515,64545,64574,64603,64633,64662,
        64691,64719,64748,64777,64805,64834,64862,64890,
        64918,64946,64974,65001,65029,65057,65084,65111,
        65138,65165,65192,65219,65246,65273,65299,65326,
        65352,65379,65405,65431,65457,65483,65509,65535
    };

    typedef struct packed {
        logic       kind;
        logic [7:0] byte2;
        logic [7:0] byte1;
        logic [7:0] byte0;
    } led_word_t;

    class led_gamma_tracker;
        logic [7:0] gamma_code;
        logic [1:0] oversample;
        logic [7:0] brightness;
        logic       grb_order;
        logic [7:0] level_table [TABLE_ENTRIES];
        logic [2:0] fraction_table [TABLE_ENTRIES];
        logic [2:0] dither_step;
        logic [2:0] step_mask;
        led_word_t  expected_words [$];
        int         mismatches;

        function new();
            gamma_code  = 8'd0;
            oversample  = 2'd0;
            brightness  = 8'd255;
            grb_order   = 1'b0;
            dither_step = 3'd0;
            step_mask   = 3'd0;
            mismatches  = 0;
            foreach (level_table[i]) begin
                level_table[i]    = 8'd0;
                fraction_table[i] = 3'd0;
            end
        endfunction

        function void write_reg(logic [1:0] index, logic [7:0] value);
            case (index)
                REG_GAMMA:      gamma_code = value;
                REG_OVERSAMPLE: oversample = value[1:0];
                REG_BRIGHTNESS: brightness = value;
                REG_GRB:        grb_order  = value[0];
                default: ;
            endcase
        endfunction

        function logic [31:0] mul_round(logic [31:0] a, logic [31:0] b);
            logic [31:0] prod;
            prod = 32'(a[15:0]) * 32'(b[15:0]);
            return (prod + 32'd32768) >> 16;
        endfunction

        function void rebuild_curve();
            int unsigned tenths;
            int unsigned whole;
            int unsigned roots;
            int unsigned x;
            int unsigned k;
            logic [31:0] y;
            logic [31:0] full;
            tenths    = 32'(gamma_code) >> 1;
            whole     = tenths / 10;
            roots     = tenths % 10;
            full      = 32'd255 << oversample;
            step_mask = 3'((4'd1 << oversample) - 4'd1);
            for (x = 1; x < TABLE_ENTRIES; x++) begin
                y = 32'd65280;
                for (k = 0; k < whole; k++) y = mul_round(y, x * 257);
                for (k = 0; k < roots; k++) y = mul_round(y, 32'(ROOT_Q16[x]));
                y = mul_round(y, full);
                level_table[x]    = 8'(y >> oversample);
                fraction_table[x] = 3'(y) & step_mask;
            end
        endfunction

        function logic [7:0] corrected(logic [7:0] raw);
            logic [15:0] scaled;
            logic [7:0]  index;
            logic [8:0]  level;
            if (gamma_code == 8'd0) return raw;
            scaled = 16'(raw) * 16'(brightness);
            index  = scaled[15:8];
            level  = {1'b0, level_table[index]};
            if (fraction_table[index] > dither_step && level < 9'd255) level++;
            return level[7:0];
        endfunction

        function void note_item(logic cmd, logic [23:0] data, logic last);
            led_word_t  want;
            logic [7:0] red;
            logic [7:0] green;
            want = '0;
            if (cmd == CMD_REBUILD) begin
                rebuild_curve();
                want.kind = KIND_REBUILT;
            end else begin
                red        = corrected(data[7:0]);
                green      = corrected(data[15:8]);
                want.kind  = KIND_PIXEL;
                want.byte0 = grb_order ? green : red;
                want.byte1 = grb_order ? red : green;
                want.byte2 = corrected(data[23:16]);
                if (last) dither_step = (dither_step + 3'd1) & step_mask;
            end
            expected_words.push_back(want);
        endfunction

        function void flag(string what, led_word_t want, led_word_t got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s: expected kind %0d bytes %02h %02h %02h, %s %0d bytes %02h %02h %02h",
                         what, want.kind, want.byte0, want.byte1, want.byte2,
                         "got kind", got.kind, got.byte0, got.byte1, got.byte2);
            end
        endfunction

        function void check_result(led_word_t got);
            led_word_t want;
            if (expected_words.size() == 0) begin
                flag("Unexpected result", '0, got);
                return;
            end
            want = expected_words.pop_front();
            if (got.kind !== want.kind || got.byte0 !== want.byte0 ||
                got.byte1 !== want.byte1 || got.byte2 !== want.byte2) begin
                flag("Result mismatch", want, got);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    led_gamma_tracker tracker;
    int unsigned      items_sent;
    int unsigned      hold_left;
    int unsigned      quiet_cycles;
    logic             tx_gaps;
    logic             rx_gaps;

    gamma_dither_corrector_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_result({m_tuser, m_tdata});
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("gamma_dither_corrector_unit regression: fail");
            $finish;
        end
    end

    initial begin
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                if (rx_gaps && $urandom_range(0, 6) == 0) stall_left = $urandom_range(1, 17);
            end
        end
    end

    task automatic drain();
        s_tvalid = 1'b0;
        while (tracker.expected_words.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
        drain();
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        tracker.write_reg(index, value);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_item(input logic cmd, input logic [23:0] data, input logic last);
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = data;
        s_tlast  = last;
        do @(posedge aclk); while (!s_tready);
        tracker.note_item(cmd, data, last);
        items_sent++;
        @(negedge aclk);
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_gamma();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return 8'd255;
        if (roll < 3) return 8'd0;
        if (roll < 5) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(1, 120));
    endfunction

    task automatic send_random_pixel();
        send_item(CMD_PIXEL, {pick_level(), pick_level(), pick_level()},
                  $urandom_range(0, 5) == 0);
    endtask

    initial begin
        int unsigned i;
        tracker      = new();
        items_sent   = 0;
        hold_left    = 0;
        quiet_cycles = 0;
        tx_gaps      = 1'b1;
        rx_gaps      = 1'b1;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 24'd0;
        s_tuser      = CMD_PIXEL;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_GAMMA;
        cfg_data     = 8'd0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Bytes pass unchanged with gamma off; afterwards the unbuilt table reads zero.
        send_item(CMD_PIXEL, 24'h000000, 1'b0);
        send_item(CMD_PIXEL, 24'hFFFFFF, 1'b1);
        send_item(CMD_PIXEL, 24'hC35AA5, 1'b0);
        write_reg(REG_GAMMA, 8'd44);
        send_item(CMD_PIXEL, 24'hFFFFFF, 1'b0);
        send_item(CMD_PIXEL, 24'h808080, 1'b1);

        // Deepest dither with GRB order; the frame marker on a rebuild is ignored.
        write_reg(REG_OVERSAMPLE, 8'd3);
        write_reg(REG_GRB, 8'd1);
        send_item(CMD_REBUILD, 24'h5A3C96, 1'b1);
        for (i = 0; i < 8; i++) send_item(CMD_PIXEL, {8'(i * 37), 8'hC1, 8'h3E}, 1'b1);
        write_reg(REG_BRIGHTNESS, 8'd0);
        send_item(CMD_PIXEL, 24'hFFFFFF, 1'b1);
        write_reg(REG_GRB, 8'd0);
        write_reg(REG_BRIGHTNESS, 8'd255);

        write_reg(REG_GAMMA, 8'd255);
        write_reg(REG_OVERSAMPLE, 8'd0);
        send_item(CMD_REBUILD, 24'hFFFFFF, 1'b0);
        send_item(CMD_PIXEL, 24'hFE0201, 1'b0);
        send_item(CMD_PIXEL, 24'hFFFFFF, 1'b1);
        write_reg(REG_GAMMA, 8'd1);
        write_reg(REG_OVERSAMPLE, 8'd2);
        send_item(CMD_REBUILD, 24'h000000, 1'b0);
        send_item(CMD_PIXEL, 24'h7F8081, 1'b1);

        // The receiver holds off while the sender keeps offering items.
        drain();
        hold_left = HOLD_CYCLES;
        tx_gaps   = 1'b0;
        repeat (30) send_random_pixel();
        drain();

        while (items_sent < ITEM_TARGET) begin
            if (items_sent + CLOSING_ITEMS >= ITEM_TARGET) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end else begin
                tx_gaps = $urandom_range(0, 3) != 0;
                rx_gaps = $urandom_range(0, 3) != 0;
            end
            if ($urandom_range(0, 1)) write_reg(REG_GAMMA, pick_gamma());
            if ($urandom_range(0, 1)) write_reg(REG_OVERSAMPLE, 8'($urandom_range(0, 3)));
            if ($urandom_range(0, 1)) write_reg(REG_BRIGHTNESS, pick_level());
            if ($urandom_range(0, 1)) write_reg(REG_GRB, 8'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) != 0) begin
                send_item(CMD_REBUILD, 24'($urandom), 1'($urandom_range(0, 1)));
            end
            repeat ($urandom_range(20, 60)) begin
                if ($urandom_range(0, 49) == 0) begin
                    send_item(CMD_REBUILD, 24'($urandom), 1'($urandom_range(0, 1)));
                end else begin
                    send_random_pixel();
                end
            end
            drain();
        end

        repeat (20) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.expected_words.size() == 0) begin
            $display("gamma_dither_corrector_unit regression: pass");
        end else begin
            $display("gamma_dither_corrector_unit regression: fail");
        end
        $finish;
    end

endmodule
